@@ hw/rtl/nv12_color_bar_generator_macros.svh @@
// -----------------------------------------------------------------------------
// NV12 color bar generator assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef NV12_COLOR_BAR_GENERATOR_MACROS_SVH
`define NV12_COLOR_BAR_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NV12CB_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NV12CB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/nv12cb_pkg.sv @@
// -----------------------------------------------------------------------------
// NV12 color bar generator package
// Field widths, register indexes, defaults and the BT.601 bar colors.
// -----------------------------------------------------------------------------
`default_nettype none

package nv12cb_pkg;

   localparam int SIZE_FIELD_BITS      = 13;
   localparam int STRIDE_FIELD_BITS    = 14;
   localparam int BASE_FIELD_BITS      = 26;
   localparam int CSR_DATA_BITS        = 26;
   localparam int CSR_INDEX_BITS       = 2;

   localparam int BAR_WIDTH_DEFAULT    = 128;
   localparam int MAX_WIDTH_DEFAULT    = 4096;
   localparam int ADDRESS_BITS_DEFAULT = 26;

   localparam logic [SIZE_FIELD_BITS-1:0]   ACTIVE_WIDTH_RESET  = 13'd1920;
   localparam logic [SIZE_FIELD_BITS-1:0]   ACTIVE_HEIGHT_RESET = 13'd1080;
   localparam logic [STRIDE_FIELD_BITS-1:0] LINE_STRIDE_RESET   = 14'd2048;
   localparam logic [BASE_FIELD_BITS-1:0]   CHROMA_BASE_RESET   = 26'd2211840;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ACTIVE_WIDTH  = 2'd0,
      CSR_ACTIVE_HEIGHT = 2'd1,
      CSR_LINE_STRIDE   = 2'd2,
      CSR_CHROMA_BASE   = 2'd3
   } csr_index_type;

   localparam int COLOR_LEVEL = 192;

   // Rounded and floored (sum + 128) >> 8, plus the channel offset, kept to a byte.
   function automatic logic [7:0] to_byte(input int sum, input int offset);
      int biased;
      biased = (sum + 128 + 65536) >>> 8;
      return 8'(biased - 256 + offset);
   endfunction

   localparam logic [7:0] RED_Y   = to_byte(66 * COLOR_LEVEL, 16);
   localparam logic [7:0] RED_CB  = to_byte(-38 * COLOR_LEVEL, 128);
   localparam logic [7:0] RED_CR  = to_byte(112 * COLOR_LEVEL, 128);
   localparam logic [7:0] BLUE_Y  = to_byte(25 * COLOR_LEVEL, 16);
   localparam logic [7:0] BLUE_CB = to_byte(112 * COLOR_LEVEL, 128);
   localparam logic [7:0] BLUE_CR = to_byte(-18 * COLOR_LEVEL, 128);

endpackage

`default_nettype wire

@@ hw/rtl/nv12cb_if.sv @@
// -----------------------------------------------------------------------------
// NV12 color bar generator channels
// Request, response and register write channels with valid/ready handshakes.
// -----------------------------------------------------------------------------
`default_nettype none

interface nv12cb_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
   modport monitor (input valid, input restart, input ready);
endinterface

interface nv12cb_rsp_if #(
   parameter int ADDRESS_BITS = nv12cb_pkg::ADDRESS_BITS_DEFAULT
);
   logic                    valid;
   logic                    ready;
   logic [ADDRESS_BITS-1:0] luma_address;
   logic [7:0]              luma_value;
   logic [ADDRESS_BITS-1:0] cb_address;
   logic [7:0]              cb_value;
   logic [ADDRESS_BITS-1:0] cr_address;
   logic [7:0]              cr_value;
   logic                    frame_end;

   modport source (output valid, output luma_address, output luma_value,
                   output cb_address, output cb_value, output cr_address,
                   output cr_value, output frame_end, input ready);
   modport sink (input valid, input luma_address, input luma_value,
                 input cb_address, input cb_value, input cr_address,
                 input cr_value, input frame_end, output ready);
   modport monitor (input valid, input luma_address, input luma_value,
                    input cb_address, input cb_value, input cr_address,
                    input cr_value, input frame_end, input ready);
endinterface

interface nv12cb_csr_if;
   import nv12cb_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
   modport monitor (input valid, input index, input data, input ready);
endinterface

`default_nettype wire

@@ hw/rtl/nv12_color_bar_generator.sv @@
// -----------------------------------------------------------------------------
// NV12 color bar generator
// Produces one NV12 pixel per accepted request: luma and chroma addresses and
// the BT.601 values of alternating red and blue bars.
// -----------------------------------------------------------------------------
// Each accepted request yields exactly one response in the next cycle, and a new
// request is taken in every cycle in which the response register is empty or
// being drained, so the block sustains one pixel per clock; the column, row and
// address counters all advance together on each accepted request. A request
// with restart set begins a new frame at pixel zero with the first bar red.
// Whenever a pixel at column zero of row zero is produced, the row start
// addresses are reloaded, so a new chroma base takes effect at the next frame.
// Register writes are always accepted and should be made while the block idles.
`default_nettype none

module nv12_color_bar_generator #(
   parameter int BAR_WIDTH    = nv12cb_pkg::BAR_WIDTH_DEFAULT,
   parameter int MAX_WIDTH    = nv12cb_pkg::MAX_WIDTH_DEFAULT,
   parameter int ADDRESS_BITS = nv12cb_pkg::ADDRESS_BITS_DEFAULT
) (
   input  wire           clock,
   input  wire           reset,
   nv12cb_req_if.sink    req_bus,
   nv12cb_rsp_if.source  rsp_bus,
   nv12cb_csr_if.sink    csr_bus
);
   import nv12cb_pkg::*;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int SIZE_BITS = COL_BITS + 1;
   localparam int BAR_BITS  = (BAR_WIDTH > 1) ? $clog2(BAR_WIDTH) : 1;

   logic [SIZE_FIELD_BITS-1:0]   active_width_ff;
   logic [SIZE_FIELD_BITS-1:0]   active_height_ff;
   logic [STRIDE_FIELD_BITS-1:0] line_stride_ff;
   logic [BASE_FIELD_BITS-1:0]   chroma_base_ff;

   logic [COL_BITS-1:0]     column_ff, column_in, column_cur;
   logic [COL_BITS-1:0]     row_ff, row_in, row_cur;
   logic [BAR_BITS-1:0]     bar_ff, bar_in, bar_cur;
   logic                    red_phase_ff, red_phase_in, red_phase_cur;
   logic [ADDRESS_BITS-1:0] luma_row_ff, luma_row_in, luma_row_cur;
   logic [ADDRESS_BITS-1:0] chroma_row_ff, chroma_row_in, chroma_row_cur;

   logic [SIZE_BITS-1:0]    last_column, last_row;
   logic                    at_last_column, at_last_row;
   logic [ADDRESS_BITS-1:0] cb_address_cur;
   logic [ADDRESS_BITS-1:0] stride_ext;

   logic                    rsp_valid_ff;
   logic [ADDRESS_BITS-1:0] luma_address_ff, cb_address_ff, cr_address_ff;
   logic [7:0]              luma_value_ff, cb_value_ff, cr_value_ff;
   logic                    frame_end_ff;

   logic take_request;

   function automatic logic [SIZE_BITS-1:0] last_index(input logic [SIZE_FIELD_BITS-1:0] size);
      logic [SIZE_BITS-1:0] result;
      priority if (size == '0) begin
         result = '0;
      end else if (int'(size) > MAX_WIDTH) begin
         result = SIZE_BITS'(MAX_WIDTH - 1);
      end else begin
         result = SIZE_BITS'(size - 1'b1);
      end
      return result;
   endfunction

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_width_ff  <= ACTIVE_WIDTH_RESET;
         active_height_ff <= ACTIVE_HEIGHT_RESET;
         line_stride_ff   <= LINE_STRIDE_RESET;
         chroma_base_ff   <= CHROMA_BASE_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_ACTIVE_WIDTH: begin
               active_width_ff <= csr_bus.data[SIZE_FIELD_BITS-1:0];
            end
            CSR_ACTIVE_HEIGHT: begin
               active_height_ff <= csr_bus.data[SIZE_FIELD_BITS-1:0];
            end
            CSR_LINE_STRIDE: begin
               line_stride_ff <= csr_bus.data[STRIDE_FIELD_BITS-1:0];
            end
            CSR_CHROMA_BASE: begin
               chroma_base_ff <= csr_bus.data[BASE_FIELD_BITS-1:0];
            end
         endcase
      end
   end

   assign take_request  = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;

   assign last_column = last_index(active_width_ff);
   assign last_row    = last_index(active_height_ff);
   assign stride_ext  = ADDRESS_BITS'(line_stride_ff);

   always_comb begin
      column_cur    = req_bus.restart ? '0 : column_ff;
      row_cur       = req_bus.restart ? '0 : row_ff;
      bar_cur       = req_bus.restart ? '0 : bar_ff;
      red_phase_cur = req_bus.restart ? 1'b0 : red_phase_ff;
      if (bar_cur == '0) begin
         red_phase_cur = !red_phase_cur;
      end

      if (column_cur == '0 && row_cur == '0) begin
         luma_row_cur   = '0;
         chroma_row_cur = ADDRESS_BITS'(chroma_base_ff);
      end else begin
         luma_row_cur   = luma_row_ff;
         chroma_row_cur = chroma_row_ff;
      end

      at_last_column = {1'b0, column_cur} >= last_column;
      at_last_row    = {1'b0, row_cur} >= last_row;
      cb_address_cur = chroma_row_cur
                     + ADDRESS_BITS'({column_cur[COL_BITS-1:1], 1'b0});

      column_in     = '0;
      row_in        = row_cur;
      bar_in        = '0;
      red_phase_in  = red_phase_cur;
      luma_row_in   = luma_row_cur;
      chroma_row_in = chroma_row_cur;
      priority if (!at_last_column) begin
         column_in = column_cur + 1'b1;
         bar_in    = (bar_cur == BAR_BITS'(BAR_WIDTH - 1)) ? '0 : bar_cur + 1'b1;
      end else if (at_last_row) begin
         row_in       = '0;
         red_phase_in = 1'b0;
      end else begin
         row_in      = row_cur + 1'b1;
         luma_row_in = luma_row_cur + stride_ext;
         if (row_cur[0]) begin
            chroma_row_in = chroma_row_cur + stride_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         row_ff        <= '0;
         bar_ff        <= '0;
         red_phase_ff  <= 1'b0;
         luma_row_ff   <= '0;
         chroma_row_ff <= ADDRESS_BITS'(CHROMA_BASE_RESET);
      end else if (take_request) begin
         column_ff     <= column_in;
         row_ff        <= row_in;
         bar_ff        <= bar_in;
         red_phase_ff  <= red_phase_in;
         luma_row_ff   <= luma_row_in;
         chroma_row_ff <= chroma_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take_request) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take_request) begin
         luma_address_ff <= luma_row_cur + ADDRESS_BITS'(column_cur);
         cb_address_ff   <= cb_address_cur;
         cr_address_ff   <= cb_address_cur + 1'b1;
         luma_value_ff   <= red_phase_cur ? RED_Y  : BLUE_Y;
         cb_value_ff     <= red_phase_cur ? RED_CB : BLUE_CB;
         cr_value_ff     <= red_phase_cur ? RED_CR : BLUE_CR;
         frame_end_ff    <= at_last_column && at_last_row;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.luma_address = luma_address_ff;
   assign rsp_bus.luma_value   = luma_value_ff;
   assign rsp_bus.cb_address   = cb_address_ff;
   assign rsp_bus.cb_value     = cb_value_ff;
   assign rsp_bus.cr_address   = cr_address_ff;
   assign rsp_bus.cr_value     = cr_value_ff;
   assign rsp_bus.frame_end    = frame_end_ff;

endmodule

`default_nettype wire

@@ hw/rtl/nv12cb_checker.sv @@
// -----------------------------------------------------------------------------
// NV12 color bar generator checker
// Port-level assertions on the request and response channels of the generator.
// -----------------------------------------------------------------------------
`default_nettype none

`include "nv12_color_bar_generator_macros.svh"

module nv12cb_checker #(
   parameter int ADDRESS_BITS = nv12cb_pkg::ADDRESS_BITS_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   input  wire                    req_ready,
   input  wire                    req_restart,
   input  wire                    rsp_valid,
   input  wire                    rsp_ready,
   input  wire [ADDRESS_BITS-1:0] rsp_luma_address,
   input  wire [7:0]              rsp_luma_value,
   input  wire [ADDRESS_BITS-1:0] rsp_cb_address,
   input  wire [7:0]              rsp_cb_value,
   input  wire [ADDRESS_BITS-1:0] rsp_cr_address,
   input  wire [7:0]              rsp_cr_value,
   input  wire                    rsp_frame_end
);
   import nv12cb_pkg::*;

   wire req_take     = req_valid && req_ready;
   wire restart_take = req_take && req_restart;
   wire rsp_stall    = rsp_valid && !rsp_ready;
   wire red_pixel    = rsp_luma_value == RED_Y && rsp_cb_value == RED_CB
                       && rsp_cr_value == RED_CR;
   wire blue_pixel   = rsp_luma_value == BLUE_Y && rsp_cb_value == BLUE_CB
                       && rsp_cr_value == BLUE_CR;
   wire bar_pixel    = red_pixel || blue_pixel;
   wire cr_addr_ok   = rsp_cr_address == rsp_cb_address + 1'b1;
   wire origin_red   = rsp_luma_address == '0 && red_pixel;

   wire [3*ADDRESS_BITS+24:0] rsp_payload = {rsp_luma_address, rsp_luma_value,
                                             rsp_cb_address, rsp_cb_value,
                                             rsp_cr_address, rsp_cr_value,
                                             rsp_frame_end};

   `NV12CB_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stall lost")

   `NV12CB_ASSERT_NEXT(a_request_yields_response, req_take, rsp_valid, "no response")

   `NV12CB_ASSERT_SAME(a_bar_color, rsp_valid, bar_pixel, "pixel is not a bar color")

   `NV12CB_ASSERT_SAME(a_cr_follows_cb, rsp_valid, cr_addr_ok, "bad Cr address")

   `NV12CB_ASSERT_NEXT(a_restart_origin, restart_take, origin_red, "restart not at red origin")

endmodule

bind nv12_color_bar_generator nv12cb_checker #(
   .ADDRESS_BITS (ADDRESS_BITS)
) u_nv12cb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .req_restart      (req_bus.restart),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_luma_address (rsp_bus.luma_address),
   .rsp_luma_value   (rsp_bus.luma_value),
   .rsp_cb_address   (rsp_bus.cb_address),
   .rsp_cb_value     (rsp_bus.cb_value),
   .rsp_cr_address   (rsp_bus.cr_address),
   .rsp_cr_value     (rsp_bus.cr_value),
   .rsp_frame_end    (rsp_bus.frame_end)
);

`default_nettype wire
